FILE: src/htq_pkg.sv
// Package for the heightmap triangle height query block.
// Holds widths, defaults, the request code and the structs between stages.
// No dependencies.
package htq_pkg;

  localparam int MAX_TILES_DEF = 255;
  localparam int FRAC_BITS_DEF = 8;
  localparam int FRAC_BITS_MAX = 12;
  localparam int OUT_FRAC      = 8;

  localparam int TILE_W      = 8;
  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 65536;
  localparam int HEIGHT_W    = 8;
  localparam int COORD_W     = 17;
  localparam int RESULT_W    = 16;
  localparam int MUL_W       = FRAC_BITS_MAX + 1;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [HEIGHT_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic [ADDR_W-1:0] addr2;
    logic [ADDR_W-1:0] addr3;
  } htq_mem_req_t;

  typedef struct packed {
    logic             valid;
    logic             in_range;
    logic             upper;
    logic [MUL_W-1:0] mul_a;
    logic [MUL_W-1:0] mul_b;
  } htq_meta_t;

endpackage

FILE: src/htq_ram.sv
// Generic single-write, dual-read synchronous RAM with registered read data.
// No dependencies.
module htq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: src/htq_front.sv
// Front end: range check, cell and fraction split, corner addresses, memory requests.
// Depends on htq_pkg.
module htq_front
  import htq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [TILE_W-1:0]          tile_count,
  input  logic                       in_valid,
  input  logic                       req_type,
  input  logic [ADDR_W-1:0]          cell_index,
  input  logic [HEIGHT_W-1:0]        height_byte,
  input  logic signed [COORD_W-1:0]  query_x,
  input  logic signed [COORD_W-1:0]  query_z,
  output htq_mem_req_t               mem_req,
  output htq_meta_t                  meta
);

  localparam int LIM_W = TILE_W + FRAC_BITS;
  localparam int MAG_W = COORD_W - 1;
  localparam int CMP_W = (LIM_W > MAG_W) ? LIM_W : MAG_W;

  logic [LIM_W-1:0]           lim;
  logic [CMP_W-1:0]           x_ext;
  logic [CMP_W-1:0]           z_ext;
  logic [CMP_W-1:0]           lim_ext;
  logic                       range_ok;
  logic [TILE_W-1:0]          nx;
  logic [TILE_W-1:0]          nz;
  logic [TILE_W:0]            stride;
  logic [2*TILE_W:0]          row_prod;

  logic                       s1_valid;
  logic                       s1_query;
  logic                       s1_in_range;
  logic [ADDR_W-1:0]          s1_waddr;
  logic [HEIGHT_W-1:0]        s1_wdata;
  logic [ADDR_W-1:0]          s1_row0;
  logic [TILE_W-1:0]          s1_nx;
  logic [FRAC_BITS-1:0]       s1_fx;
  logic [FRAC_BITS-1:0]       s1_fz;

  logic [ADDR_W-1:0]          i0;
  logic [ADDR_W-1:0]          i1;
  logic [FRAC_BITS:0]         fsum;
  logic                       upper;
  logic [FRAC_BITS:0]         one_minus_fx;
  logic [FRAC_BITS:0]         one_minus_fz;
  logic [FRAC_BITS:0]         mul_a;
  logic [FRAC_BITS:0]         mul_b;
  htq_meta_t                  meta_next;

  assign lim      = {tile_count, {FRAC_BITS{1'b0}}};
  assign x_ext    = CMP_W'(query_x[MAG_W-1:0]);
  assign z_ext    = CMP_W'(query_z[MAG_W-1:0]);
  assign lim_ext  = CMP_W'(lim);
  assign range_ok = !query_x[COORD_W-1] && !query_z[COORD_W-1] &&
                    (x_ext < lim_ext) && (z_ext < lim_ext);
  assign nx       = TILE_W'(query_x[MAG_W-1:FRAC_BITS]);
  assign nz       = TILE_W'(query_z[MAG_W-1:FRAC_BITS]);
  assign stride   = {1'b0, tile_count} + (TILE_W+1)'(1);
  assign row_prod = (2*TILE_W+1)'(nz) * (2*TILE_W+1)'(stride);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_query    <= (req_type == REQ_QUERY);
      s1_in_range <= range_ok;
      s1_waddr    <= cell_index;
      s1_wdata    <= height_byte;
      s1_row0     <= row_prod[ADDR_W-1:0];
      s1_nx       <= nx;
      s1_fx       <= query_x[FRAC_BITS-1:0];
      s1_fz       <= query_z[FRAC_BITS-1:0];
    end
  end

  assign i0           = s1_row0 + ADDR_W'(s1_nx);
  assign i1           = i0 + ADDR_W'(stride);
  assign fsum         = {1'b0, s1_fx} + {1'b0, s1_fz};
  assign upper        = fsum[FRAC_BITS];
  assign one_minus_fx = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, s1_fx};
  assign one_minus_fz = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, s1_fz};
  assign mul_a        = upper ? one_minus_fx : {1'b0, s1_fz};
  assign mul_b        = upper ? one_minus_fz : {1'b0, s1_fx};

  always_comb begin
    mem_req.we    = advance && s1_valid && !s1_query;
    mem_req.waddr = s1_waddr;
    mem_req.wdata = s1_wdata;
    mem_req.re    = advance && s1_valid && s1_query;
    mem_req.addr0 = i0;
    mem_req.addr1 = i1;
    mem_req.addr2 = i1 + ADDR_W'(1);
    mem_req.addr3 = i0 + ADDR_W'(1);

    meta_next.valid    = s1_valid && s1_query;
    meta_next.in_range = s1_in_range;
    meta_next.upper    = upper;
    meta_next.mul_a    = MUL_W'(mul_a);
    meta_next.mul_b    = MUL_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta.valid <= 1'b0;
    end else if (advance) begin
      meta.valid <= meta_next.valid;
    end
    if (advance) begin
      meta.in_range <= meta_next.in_range;
      meta.upper    <= meta_next.upper;
      meta.mul_a    <= meta_next.mul_a;
      meta.mul_b    <= meta_next.mul_b;
    end
  end

endmodule

FILE: src/htq_interp.sv
// Interpolation back end: corner differences times fractions, sum, clamp, output register.
// Depends on htq_pkg.
module htq_interp
  import htq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  htq_meta_t           meta,
  input  logic [HEIGHT_W-1:0] h0,
  input  logic [HEIGHT_W-1:0] h1,
  input  logic [HEIGHT_W-1:0] h2,
  input  logic [HEIGHT_W-1:0] h3,
  output logic                out_valid,
  output logic [RESULT_W-1:0] height_q,
  output logic                in_range
);

  localparam int BASE_W = HEIGHT_W + FRAC_BITS;
  localparam int PROD_W = HEIGHT_W + 1 + FRAC_BITS + 2;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SH_W   = ACC_W - 1 + OUT_FRAC;
  localparam int SHR    = (FRAC_BITS >= OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int SHL    = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;

  logic [HEIGHT_W-1:0]        hb;
  logic signed [HEIGHT_W:0]   d_a;
  logic signed [HEIGHT_W:0]   d_b;
  logic signed [FRAC_BITS+1:0] m_a;
  logic signed [FRAC_BITS+1:0] m_b;

  logic                       s3_valid;
  logic                       s3_in_range;
  logic [BASE_W-1:0]          s3_base;
  logic signed [PROD_W-1:0]   s3_pa;
  logic signed [PROD_W-1:0]   s3_pb;

  logic signed [ACC_W-1:0]    acc;
  logic [SH_W-1:0]            wide;
  logic [SH_W-1:0]            shifted;
  logic [RESULT_W-1:0]        result;

  assign hb  = meta.upper ? h2 : h0;
  assign d_a = $signed({1'b0, h1}) - $signed({1'b0, hb});
  assign d_b = $signed({1'b0, h3}) - $signed({1'b0, hb});
  assign m_a = $signed({1'b0, meta.mul_a[FRAC_BITS:0]});
  assign m_b = $signed({1'b0, meta.mul_b[FRAC_BITS:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_in_range <= meta.in_range;
      s3_base     <= {hb, {FRAC_BITS{1'b0}}};
      s3_pa       <= PROD_W'(d_a) * PROD_W'(m_a);
      s3_pb       <= PROD_W'(d_b) * PROD_W'(m_b);
    end
  end

  always_comb begin
    acc = $signed({{(ACC_W-BASE_W){1'b0}}, s3_base})
        + $signed({s3_pa[PROD_W-1], s3_pa})
        + $signed({s3_pb[PROD_W-1], s3_pb});
    if (acc[ACC_W-1]) begin
      wide = '0;
    end else begin
      wide = SH_W'(acc[ACC_W-2:0]);
    end
    shifted = (wide << SHL) >> SHR;
    if (|shifted[SH_W-1:RESULT_W]) begin
      result = '1;
    end else begin
      result = shifted[RESULT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      height_q <= s3_in_range ? result : '0;
      in_range <= s3_in_range;
    end
  end

endmodule

FILE: src/heightmap_triangle_height_query.sv
// Heightmap triangle height query: top level with config register, stores and assertions.
// Depends on htq_pkg, htq_ram, htq_front, htq_interp.
//
// One beat is accepted per clock while the output is not stalled. A query beat gives its
// result beat out of the fourth register stage (address register, memory read, multiply,
// sum and output register); a load beat writes its height when it leaves the address
// register and gives no result. A stalled output holds the whole pipeline and stalls the
// input. Heights live in two identical 64K x 8 memories, each with two read ports, so
// the four cell corners are read together; loads write both. There is no clearing pass:
// a height read before it was loaded is undefined.
module heightmap_triangle_height_query
  import htq_pkg::*;
#(
  parameter int MAX_TILES = MAX_TILES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [TILE_W-1:0]         cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      req_type,
  input  logic [ADDR_W-1:0]         cell_index,
  input  logic [HEIGHT_W-1:0]       height_byte,
  input  logic signed [COORD_W-1:0] query_x,
  input  logic signed [COORD_W-1:0] query_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [RESULT_W-1:0]       height_q,
  output logic                      in_range
);

  localparam logic [TILE_W-1:0] TILE_MAX = TILE_W'(MAX_TILES);

  logic [TILE_W-1:0]   tile_count;
  logic                advance;
  htq_mem_req_t        mem_req;
  htq_meta_t           meta;
  logic [HEIGHT_W-1:0] h0;
  logic [HEIGHT_W-1:0] h1;
  logic [HEIGHT_W-1:0] h2;
  logic [HEIGHT_W-1:0] h3;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_count <= TILE_MAX;
    end else if (cfg_wen) begin
      tile_count <= (cfg_wdata > TILE_MAX) ? TILE_MAX : cfg_wdata;
    end
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  htq_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .tile_count  (tile_count),
    .in_valid    (in_valid),
    .req_type    (req_type),
    .cell_index  (cell_index),
    .height_byte (height_byte),
    .query_x     (query_x),
    .query_z     (query_z),
    .mem_req     (mem_req),
    .meta        (meta)
  );

  htq_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram_even (
    .clk     (clk),
    .we      (mem_req.we),
    .waddr   (mem_req.waddr),
    .wdata   (mem_req.wdata),
    .re      (mem_req.re),
    .raddr_a (mem_req.addr0),
    .raddr_b (mem_req.addr2),
    .rdata_a (h0),
    .rdata_b (h2)
  );

  htq_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram_odd (
    .clk     (clk),
    .we      (mem_req.we),
    .waddr   (mem_req.waddr),
    .wdata   (mem_req.wdata),
    .re      (mem_req.re),
    .raddr_a (mem_req.addr1),
    .raddr_b (mem_req.addr3),
    .rdata_a (h1),
    .rdata_b (h3)
  );

  htq_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .meta      (meta),
    .h0        (h0),
    .h1        (h1),
    .h2        (h2),
    .h3        (h3),
    .out_valid (out_valid),
    .height_q  (height_q),
    .in_range  (in_range)
  );

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> height_q == '0)
    else $error("out-of-range result with nonzero height");

  assert property (@(posedge clk) disable iff (rst)
    tile_count <= TILE_MAX)
    else $error("tile count above maximum");

  assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> !mem_req.re)
    else $error("store written and read in the same cycle");

  assert property (@(posedge clk) disable iff (rst)
    mem_req.re |=> meta.valid)
    else $error("store read without a query entering the multiply stage");

endmodule

FILE: tb/terrain_height_checker.sv
// Checker for the heightmap triangle height query block: watches both channels,
// keeps a shadow height grid and tile count, predicts each query and compares it.
// Depends on htq_pkg.
module terrain_height_checker
  import htq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [TILE_W-1:0]         cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      req_type,
  input  logic [ADDR_W-1:0]         cell_index,
  input  logic [HEIGHT_W-1:0]       height_byte,
  input  logic signed [COORD_W-1:0] query_x,
  input  logic signed [COORD_W-1:0] query_z,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [RESULT_W-1:0]       height_q,
  input  logic                      in_range,
  output int                        error_count,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_ONE = 1 << FRAC_BITS_DEF;

  typedef struct {
    logic [RESULT_W-1:0] height;
    logic                in_range;
  } height_beat_t;

  logic [HEIGHT_W-1:0] heights [STORE_DEPTH];
  logic [TILE_W-1:0]   tiles;
  height_beat_t        height_expected [$];

  function automatic height_beat_t predict_height(logic signed [COORD_W-1:0] qx,
                                                  logic signed [COORD_W-1:0] qz);
    height_beat_t beat;
    int sx, sz, lim, nx, nz, fx, fz, stride, acc, h0, h1, h2, h3;
    sx = qx;
    sz = qz;
    lim = int'(tiles) * GRID_ONE;
    beat.height = '0;
    beat.in_range = 1'b0;
    if (sx < 0 || sz < 0 || sx >= lim || sz >= lim) return beat;
    nx = sx >> FRAC_BITS_DEF;
    nz = sz >> FRAC_BITS_DEF;
    fx = sx & (GRID_ONE - 1);
    fz = sz & (GRID_ONE - 1);
    stride = int'(tiles) + 1;
    h0 = heights[ADDR_W'(nz * stride + nx)];
    h1 = heights[ADDR_W'((nz + 1) * stride + nx)];
    h2 = heights[ADDR_W'((nz + 1) * stride + nx + 1)];
    h3 = heights[ADDR_W'(nz * stride + nx + 1)];
    if (fx + fz < GRID_ONE) begin
      acc = h0 * GRID_ONE + (h1 - h0) * fz + (h3 - h0) * fx;
    end else begin
      acc = h2 * GRID_ONE + (h1 - h2) * (GRID_ONE - fx) + (h3 - h2) * (GRID_ONE - fz);
    end
    if (acc < 0) acc = 0;
    if (FRAC_BITS_DEF >= OUT_FRAC) begin
      acc = acc >> (FRAC_BITS_DEF - OUT_FRAC);
    end else begin
      acc = acc << (OUT_FRAC - FRAC_BITS_DEF);
    end
    if (acc > 65535) acc = 65535;
    beat.height = RESULT_W'(acc);
    beat.in_range = 1'b1;
    return beat;
  endfunction

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    height_beat_t want;
    if (rst) begin
      tiles = TILE_W'(MAX_TILES_DEF);
    end else begin
      if (cfg_wen) begin
        tiles = (int'(cfg_wdata) > MAX_TILES_DEF) ? TILE_W'(MAX_TILES_DEF) : cfg_wdata;
      end
      // retire the result beat before taking a new query
      if (out_valid && !out_stall) begin
        if (height_expected.size() == 0) begin
          $display("%0t: result beat with no query waiting: height %0d in_range %0b",
                   $time, height_q, in_range);
          error_count++;
        end else begin
          want = height_expected.pop_front();
          if (in_range !== want.in_range) begin
            $display("%0t: in_range mismatch: expected %0b, got %0b",
                     $time, want.in_range, in_range);
            error_count++;
          end
          if (height_q !== want.height) begin
            $display("%0t: height mismatch: expected %0d, got %0d",
                     $time, want.height, height_q);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (req_t'(req_type) == REQ_LOAD) begin
          heights[cell_index] = height_byte;
        end else begin
          height_expected.insert(height_expected.size(), predict_height(query_x, query_z));
        end
      end
    end
    outstanding = height_expected.size();
  end

endmodule

FILE: tb/tb.sv
// Top of the height query testbench: clock, reset, load and query stimulus with
// bursty input and patterned output stalls, and the final verdict.
// Depends on htq_pkg, heightmap_triangle_height_query and terrain_height_checker.
module tb
  import htq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {FLOW, LIGHT, HEAVY, TOGGLE} stall_mode_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_wen;
  logic [TILE_W-1:0]         cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  logic                      req_type;
  logic [ADDR_W-1:0]         cell_index;
  logic [HEIGHT_W-1:0]       height_byte;
  logic signed [COORD_W-1:0] query_x;
  logic signed [COORD_W-1:0] query_z;
  logic                      out_valid;
  logic                      out_stall;
  logic [RESULT_W-1:0]       height_q;
  logic                      in_range;
  int                        error_count;
  int                        outstanding;

  bit loaded [STORE_DEPTH];
  bit hold_req = 1'b0;
  int tiles_now = MAX_TILES_DEF;
  int burst_left = 0;
  int beats_sent = 0;

  heightmap_triangle_height_query dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .cell_index(cell_index), .height_byte(height_byte),
    .query_x(query_x), .query_z(query_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .height_q(height_q), .in_range(in_range)
  );

  terrain_height_checker checker_i (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .cell_index(cell_index), .height_byte(height_byte),
    .query_x(query_x), .query_z(query_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .height_q(height_q), .in_range(in_range),
    .error_count(error_count), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic send(req_t kind, logic [ADDR_W-1:0] idx, logic [HEIGHT_W-1:0] hb,
                      logic signed [COORD_W-1:0] qx, logic signed [COORD_W-1:0] qz);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    req_type    <= kind;
    cell_index  <= idx;
    height_byte <= hb;
    query_x     <= qx;
    query_z     <= qz;
    // hold the beat until the block takes it
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    beats_sent++;
  endtask

  task automatic load_height(logic [ADDR_W-1:0] idx, logic [HEIGHT_W-1:0] hb);
    send(REQ_LOAD, idx, hb, COORD_W'($urandom), COORD_W'($urandom));
    loaded[idx] = 1'b1;
  endtask

  // load any corner of the cell that was never written, then query
  task automatic ask_height(logic signed [COORD_W-1:0] qx, logic signed [COORD_W-1:0] qz);
    int sx, sz, lim, stride, nx, nz;
    logic [ADDR_W-1:0] corner [4];
    sx = qx;
    sz = qz;
    lim = tiles_now << FRAC_BITS_DEF;
    if (sx >= 0 && sz >= 0 && sx < lim && sz < lim) begin
      nx = sx >> FRAC_BITS_DEF;
      nz = sz >> FRAC_BITS_DEF;
      stride = tiles_now + 1;
      corner[0] = ADDR_W'(nz * stride + nx);
      corner[1] = ADDR_W'((nz + 1) * stride + nx);
      corner[2] = corner[1] + ADDR_W'(1);
      corner[3] = corner[0] + ADDR_W'(1);
      foreach (corner[k]) begin
        if (!loaded[corner[k]]) load_height(corner[k], HEIGHT_W'($urandom));
      end
    end
    send(REQ_QUERY, ADDR_W'($urandom), HEIGHT_W'($urandom), qx, qz);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tiles(int count);
    settle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= TILE_W'(count);
    @(posedge clk);
    cfg_wen   <= 1'b0;
    tiles_now = count;
  endtask

  function automatic int coord_inside();
    int frac;
    case ($urandom_range(0, 3))
      0:       frac = 0;
      1:       frac = (1 << FRAC_BITS_DEF) - 1;
      default: frac = $urandom_range(0, (1 << FRAC_BITS_DEF) - 1);
    endcase
    return ($urandom_range(0, tiles_now - 1) << FRAC_BITS_DEF) + frac;
  endfunction

  task automatic random_query();
    int pick, sx, sz, tmp;
    pick = (tiles_now == 0) ? 7 : $urandom_range(0, 9);
    if (pick < 7) begin
      sx = coord_inside();
      sz = coord_inside();
    end else if (pick == 7) begin
      sx = $urandom_range(0, 131071) - 65536;
      sz = $urandom_range(0, 131071) - 65536;
    end else if (pick == 8) begin
      sx = (tiles_now << FRAC_BITS_DEF) + $urandom_range(0, 3);
      sz = coord_inside();
    end else begin
      sx = -int'($urandom_range(1, 65536));
      sz = coord_inside();
    end
    if (pick >= 8 && $urandom_range(0, 1) == 1) begin
      tmp = sx;
      sx = sz;
      sz = tmp;
    end
    ask_height(COORD_W'(sx), COORD_W'(sz));
  endtask

  initial begin : receiver
    stall_mode_t mode;
    int mode_left, hold_left;
    logic nxt;
    out_stall = 1'b0;
    mode = FLOW;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = $urandom_range(60, 120);
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 60);
        end
        mode_left--;
        case (mode)
          FLOW:    nxt = 1'b0;
          LIGHT:   nxt = ($urandom_range(0, 3) == 0);
          HEAVY:   nxt = ($urandom_range(0, 3) != 0);
          default: nxt = ~out_stall;
        endcase
      end
      @(posedge clk);
      out_stall <= nxt;
    end
  end

  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int tile_plan [7];
    int phase_end, roll;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    req_type = 1'b0;
    cell_index = '0;
    height_byte = '0;
    query_x = '0;
    query_z = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset tile count: far corner of the grid and the first coordinate past it
    ask_height(17'sd65280, 17'sd0);
    load_height(16'd65278, 8'd255);
    load_height(16'd65279, 8'd0);
    load_height(16'd65534, 8'd0);
    load_height(16'd65535, 8'd255);
    ask_height(17'sd65279, 17'sd65279);

    // single tile: both triangles, their border, and out-of-range points, negative and past the grid
    set_tiles(1);
    load_height(16'd0, 8'd0);
    load_height(16'd1, 8'd255);
    load_height(16'd2, 8'd255);
    load_height(16'd3, 8'd0);
    ask_height(17'sd0, 17'sd0);
    ask_height(17'sd255, 17'sd0);
    ask_height(17'sd0, 17'sd255);
    ask_height(17'sd255, 17'sd1);
    ask_height(17'sd128, 17'sd128);
    ask_height(17'sd255, 17'sd255);
    ask_height(17'sd256, 17'sd0);
    ask_height(-17'sd1, 17'sd0);
    ask_height(17'sd0, -17'sd65536);
    ask_height(17'sd65535, 17'sd65535);

    // zero tiles: nothing is in range
    set_tiles(0);
    ask_height(17'sd0, 17'sd0);
    ask_height(17'sd255, 17'sd255);

    tile_plan = '{255, 1, $urandom_range(2, 6), $urandom_range(7, 40), 0,
                  $urandom_range(1, 255), 255};
    foreach (tile_plan[p]) begin
      set_tiles(tile_plan[p]);
      if (p % 3 == 0) hold_req = 1'b1;
      phase_end = beats_sent + 85;
      while (beats_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          load_height(ADDR_W'($urandom), HEIGHT_W'($urandom));
        end else if (roll < 14) begin
          settle();
        end else begin
          random_query();
        end
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
